/* rtl/core/cbcr_pkg.sv */
`default_nettype none

package cbcr_pkg;

    localparam int MAX_BOXES = 32;
    localparam int ADDR_W    = $clog2(MAX_BOXES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int COUNT_W   = 6;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_RESOLVE = 2'd1;
    localparam logic [1:0] MODE_SUPPORT = 2'd2;

    localparam logic [1:0] CFG_HALF_SIZE      = 2'd0;
    localparam logic [1:0] CFG_BUILDING_COUNT = 2'd1;
    localparam logic [1:0] CFG_CLEARANCE_TOL  = 2'd2;

    localparam logic [14:0]        HALF_SIZE_RST = 15'd28160;
    localparam logic [COUNT_W-1:0] COUNT_RST     = '0;
    localparam logic [7:0]         TOL_RST       = 8'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         entry_index;
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] from_z;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic signed [15:0] to_z;
        logic [14:0]        radius;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] support_height;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_z;
        logic signed [15:0] max_x;
        logic signed [15:0] max_z;
        logic signed [15:0] top;
    } box_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic               start;
        logic signed [15:0] x;
        logic signed [15:0] z;
        logic [29:0]        r2;
        logic signed [16:0] clear;
        logic [COUNT_W-1:0] count;
    } scan_req_t;

    typedef struct packed {
        logic               done;
        logic               blocked;
        logic signed [15:0] support;
    } scan_rsp_t;

    function automatic logic signed [16:0] clamp17(
        input logic signed [16:0] v,
        input logic signed [16:0] lo,
        input logic signed [16:0] hi
    );
        logic signed [16:0] t;
        t = (v < lo) ? lo : v;
        if (t > hi)
        begin
            t = hi;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cbcr_box_mem.sv */
`default_nettype none

module cbcr_box_mem (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [cbcr_pkg::ADDR_W-1:0] wr_addr,
    input  wire cbcr_pkg::box_t              wr_data,
    input  wire cbcr_pkg::mem_rd_t           rd,
    output cbcr_pkg::box_t                   rd_data
);

    cbcr_pkg::box_t mem [cbcr_pkg::MAX_BOXES];
    cbcr_pkg::box_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/cbcr_scan.sv */
`default_nettype none

module cbcr_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cbcr_pkg::scan_req_t req,
    input  wire cbcr_pkg::box_t      rd_data,
    output cbcr_pkg::mem_rd_t        rd,
    output cbcr_pkg::scan_rsp_t      rsp
);

    logic                       busy_reg;
    logic [cbcr_pkg::CNT_W-1:0] cnt_reg;
    logic [cbcr_pkg::CNT_W-1:0] len_reg;
    logic [cbcr_pkg::CNT_W-1:0] len_next;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       blocked_reg;
    logic signed [15:0]         sup_reg;

    logic signed [15:0] x_reg;
    logic signed [15:0] z_reg;
    logic [29:0]        r2_reg;
    logic signed [16:0] clear_reg;

    logic signed [16:0] dx_reg;
    logic signed [16:0] dz_reg;
    logic signed [15:0] top2_reg;
    logic               solid2_reg;
    logic [31:0]        sqx_reg;
    logic [31:0]        sqz_reg;
    logic signed [15:0] top3_reg;
    logic               solid3_reg;

    logic               issue;
    logic               done;
    logic signed [16:0] dx_next;
    logic signed [16:0] dz_next;
    logic               solid_next;
    logic signed [33:0] prod_x;
    logic signed [33:0] prod_z;
    logic [32:0]        dist_sum;
    logic               hit;

    assign len_next = (int'(req.count) > cbcr_pkg::MAX_BOXES)
                    ? cbcr_pkg::CNT_W'(cbcr_pkg::MAX_BOXES)
                    : cbcr_pkg::CNT_W'(req.count);

    assign issue = busy_reg && (cnt_reg != len_reg);
    assign done  = busy_reg && !issue && !v1_reg && !v2_reg && !v3_reg;

    assign rd.en   = issue;
    assign rd.addr = cnt_reg[cbcr_pkg::ADDR_W-1:0];

    // nearest-point offsets on the box
    assign dx_next = 17'(x_reg) - cbcr_pkg::clamp17(17'(x_reg), 17'(rd_data.min_x),
                                                     17'(rd_data.max_x));
    assign dz_next = 17'(z_reg) - cbcr_pkg::clamp17(17'(z_reg), 17'(rd_data.min_z),
                                                     17'(rd_data.max_z));
    assign solid_next = 17'(rd_data.top) > clear_reg;

    assign prod_x = 34'(dx_reg) * 34'(dx_reg);
    assign prod_z = 34'(dz_reg) * 34'(dz_reg);

    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqz_reg};
    assign hit      = dist_sum < {3'b000, r2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            len_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            blocked_reg <= 1'b0;
            sup_reg     <= '0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                len_reg     <= len_next;
                blocked_reg <= 1'b0;
                sup_reg     <= '0;
            end
            else
            begin
                if (issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (done)
                begin
                    busy_reg <= 1'b0;
                end
                if (v3_reg && hit)
                begin
                    if (solid3_reg)
                    begin
                        blocked_reg <= 1'b1;
                    end
                    else if (top3_reg > sup_reg)
                    begin
                        sup_reg <= top3_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg     <= req.x;
            z_reg     <= req.z;
            r2_reg    <= req.r2;
            clear_reg <= req.clear;
        end
        dx_reg     <= dx_next;
        dz_reg     <= dz_next;
        top2_reg   <= rd_data.top;
        solid2_reg <= solid_next;
        sqx_reg    <= prod_x[31:0];
        sqz_reg    <= prod_z[31:0];
        top3_reg   <= top2_reg;
        solid3_reg <= solid2_reg;
    end

    assign rsp.done    = done;
    assign rsp.blocked = blocked_reg;
    assign rsp.support = sup_reg;

endmodule

`default_nettype wire

/* rtl/core/circle_box_collision_resolver.sv */
// Circle versus box collision resolver. Load items and unused-mode items
// give an all-zero result without a scan. A support query makes one pass and
// a resolve makes two passes over the box memory; a pass reads one entry per
// cycle from the single read port and covers min(building_count, 32) entries.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
`default_nettype none

module circle_box_collision_resolver (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire cbcr_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output cbcr_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [14:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_X_GO  = 3'd1;
    localparam logic [2:0] ST_X_RUN = 3'd2;
    localparam logic [2:0] ST_Z_GO  = 3'd3;
    localparam logic [2:0] ST_Z_RUN = 3'd4;
    localparam logic [2:0] ST_S_GO  = 3'd5;
    localparam logic [2:0] ST_S_RUN = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [14:0]                  half_reg;
    logic [cbcr_pkg::COUNT_W-1:0] count_reg;
    logic [7:0]                   tol_reg;

    cbcr_pkg::in_item_t  item_reg;
    logic signed [16:0]  lo_reg;
    logic signed [16:0]  hi_reg;
    logic [29:0]         r2_reg;
    logic signed [16:0]  clear_reg;
    logic signed [15:0]  nx_reg;
    logic signed [15:0]  nz_reg;
    logic signed [15:0]  px_reg;
    logic signed [15:0]  pz_reg;
    logic signed [15:0]  sup_reg;
    cbcr_pkg::out_item_t out_reg;
    logic                out_valid_reg;

    logic                accept;
    logic                out_free;
    logic signed [15:0]  cx;
    logic signed [15:0]  cz;
    logic signed [16:0]  cx_full;
    logic signed [16:0]  cz_full;
    cbcr_pkg::out_item_t result;
    cbcr_pkg::scan_req_t scan_req;
    cbcr_pkg::scan_rsp_t scan_rsp;
    cbcr_pkg::mem_rd_t   mem_rd;
    cbcr_pkg::box_t      mem_rd_data;
    cbcr_pkg::box_t      mem_wr_data;
    logic                mem_wr_en;

    assign in_stall  = state_reg != ST_IDLE;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign mem_wr_en = accept && (in_data.mode == cbcr_pkg::MODE_LOAD)
                     && (int'(in_data.entry_index) < cbcr_pkg::MAX_BOXES);
    assign mem_wr_data.min_x = in_data.from_x;
    assign mem_wr_data.min_z = in_data.from_z;
    assign mem_wr_data.max_x = in_data.to_x;
    assign mem_wr_data.max_z = in_data.to_z;
    assign mem_wr_data.top   = in_data.to_y;

    cbcr_box_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (cbcr_pkg::ADDR_W'(in_data.entry_index)),
        .wr_data (mem_wr_data),
        .rd      (mem_rd),
        .rd_data (mem_rd_data)
    );

    cbcr_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .rd_data (mem_rd_data),
        .rd      (mem_rd),
        .rsp     (scan_rsp)
    );

    assign cx_full = cbcr_pkg::clamp17(17'(item_reg.to_x), lo_reg, hi_reg);
    assign cz_full = cbcr_pkg::clamp17(17'(item_reg.to_z), lo_reg, hi_reg);
    assign cx = cx_full[15:0];
    assign cz = cz_full[15:0];

    always_comb
    begin
        scan_req.start = (state_reg == ST_X_GO) || (state_reg == ST_Z_GO)
                       || (state_reg == ST_S_GO);
        scan_req.x     = item_reg.from_x;
        scan_req.z     = item_reg.from_z;
        scan_req.r2    = r2_reg;
        scan_req.clear = clear_reg;
        scan_req.count = count_reg;
        case (state_reg)
            ST_X_GO:
            begin
                scan_req.x = cx;
            end
            ST_Z_GO:
            begin
                scan_req.x = px_reg;
                scan_req.z = cz;
            end
            default:
            begin
                scan_req.x = item_reg.from_x;
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        case (item_reg.mode)
            cbcr_pkg::MODE_RESOLVE:
            begin
                result.pos_x = px_reg;
                result.pos_y = item_reg.to_y;
                result.pos_z = pz_reg;
            end
            cbcr_pkg::MODE_SUPPORT:
            begin
                result.support_height = sup_reg;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.mode)
                        cbcr_pkg::MODE_RESOLVE: state_next = ST_X_GO;
                        cbcr_pkg::MODE_SUPPORT: state_next = ST_S_GO;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_X_GO:  state_next = ST_X_RUN;
            ST_X_RUN: state_next = scan_rsp.done ? ST_Z_GO : ST_X_RUN;
            ST_Z_GO:  state_next = ST_Z_RUN;
            ST_Z_RUN: state_next = scan_rsp.done ? ST_DONE : ST_Z_RUN;
            ST_S_GO:  state_next = ST_S_RUN;
            ST_S_RUN: state_next = scan_rsp.done ? ST_DONE : ST_S_RUN;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            half_reg      <= cbcr_pkg::HALF_SIZE_RST;
            count_reg     <= cbcr_pkg::COUNT_RST;
            tol_reg       <= cbcr_pkg::TOL_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cbcr_pkg::CFG_HALF_SIZE:      half_reg  <= cfg_data;
                    cbcr_pkg::CFG_BUILDING_COUNT: count_reg <= cfg_data[cbcr_pkg::COUNT_W-1:0];
                    cbcr_pkg::CFG_CLEARANCE_TOL:  tol_reg   <= cfg_data[7:0];
                    default:                      half_reg  <= half_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= in_data;
            lo_reg    <= $signed({2'b00, in_data.radius}) - $signed({2'b00, half_reg});
            hi_reg    <= $signed({2'b00, half_reg}) - $signed({2'b00, in_data.radius});
            r2_reg    <= 30'(in_data.radius) * 30'(in_data.radius);
            clear_reg <= 17'(in_data.from_y) + $signed({9'd0, tol_reg});
            px_reg    <= in_data.from_x;
            pz_reg    <= in_data.from_z;
        end
        if (state_reg == ST_X_GO)
        begin
            nx_reg <= cx;
        end
        if (state_reg == ST_Z_GO)
        begin
            nz_reg <= cz;
        end
        if (state_reg == ST_X_RUN && scan_rsp.done && !scan_rsp.blocked)
        begin
            px_reg <= nx_reg;
        end
        if (state_reg == ST_Z_RUN && scan_rsp.done && !scan_rsp.blocked)
        begin
            pz_reg <= nz_reg;
        end
        if (state_reg == ST_S_RUN && scan_rsp.done)
        begin
            sup_reg <= scan_rsp.support;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* rtl/core/cbcr_checker.sv */
`default_nettype none

module cbcr_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire cbcr_pkg::out_item_t out_data
);

    logic [2:0] pend_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {2'b00, in_xfer} - {2'b00, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd2)
        else $error("too many items in flight");

    a_stall_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input not held off after transfer");

    a_support_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.support_height == 16'sd0)
                      || (out_data.pos_x == 16'sd0 && out_data.pos_y == 16'sd0
                          && out_data.pos_z == 16'sd0))
        else $error("support result mixed with position");

endmodule

bind circle_box_collision_resolver cbcr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
